// ----- rtl/core/terminal_text_cell_buffer_macros.svh -----
// assertion macros for the terminal text cell buffer
// used by rtl files that assert; expects clk_i and rst_ni in scope
`ifndef TERMINAL_TEXT_CELL_BUFFER_MACROS_SVH
`define TERMINAL_TEXT_CELL_BUFFER_MACROS_SVH
`ifndef SYNTHESIS
// property that holds on every clock edge out of reset
`define TTCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define TTCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TTCB_ASSERT(lbl, prop, msg)
`define TTCB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/ttcb_pkg.sv -----
// shared types, constants and the line graphics table of the text cell buffer
// no dependencies
`default_nettype none

package ttcb_pkg;

  localparam int ROWS_DEF   = 64;
  localparam int COLS_DEF   = 128;
  localparam int VAL_W      = 21;
  localparam int ATTR_W     = 16;
  localparam int CELL_W     = VAL_W + ATTR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 56;
  localparam int OUT_ROW_W  = 6;
  localparam int OUT_COL_W  = 8;

  localparam logic [VAL_W-1:0] SPACE_CHAR = 21'h20;
  localparam logic [VAL_W-1:0] GFX_LO     = 21'h41;
  localparam logic [VAL_W-1:0] GFX_HI     = 21'h7e;

  typedef enum logic [3:0] {
    ACT_PUT      = 4'd0,
    ACT_MOVETO   = 4'd1,
    ACT_MOVEBY   = 4'd2,
    ACT_LINEFEED = 4'd3,
    ACT_TABFWD   = 4'd4,
    ACT_TABBACK  = 4'd5,
    ACT_INSCHARS = 4'd6,
    ACT_DELCHARS = 4'd7,
    ACT_SCROLLUP = 4'd8,
    ACT_SCROLLDN = 4'd9,
    ACT_SAVE     = 4'd10,
    ACT_RESTORE  = 4'd11,
    ACT_READ     = 4'd12,
    ACT_WRITE    = 4'd13
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCROLL_TOP = 3'd0,
    REG_SCROLL_BOT = 3'd1,
    REG_FILL_ATTRS = 3'd2,
    REG_LINE_GFX   = 3'd3,
    REG_TAB_WIDTH  = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_TAB_MOD,
    ST_TAB_STEP,
    ST_SC_SETUP,
    ST_MV_SETUP,
    ST_CP_RD,
    ST_CP_WR,
    ST_BLANK,
    ST_PUT_WR,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MV_SCUP,
    MV_SCDN,
    MV_INS,
    MV_DEL
  } mv_mode_e;

  // dec special graphics for 0x41..0x7e, zero means no translation
  localparam logic [15:0] GFX_TABLE [62] = '{
    16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h2588, 16'h259A, 16'h2603,
    16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
    16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
    16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0020,
    16'h25C6, 16'h2592, 16'h2409, 16'h240C, 16'h240D, 16'h240A, 16'h00B0, 16'h00B1,
    16'h2424, 16'h240B, 16'h2518, 16'h2510, 16'h250C, 16'h2514, 16'h253C, 16'h23BA,
    16'h23BB, 16'h2500, 16'h23BC, 16'h23BD, 16'h251C, 16'h2524, 16'h2534, 16'h252C,
    16'h2502, 16'h2264, 16'h2265, 16'h03C0, 16'h2260, 16'h00A3, 16'h00B7
  };

  function automatic logic [VAL_W-1:0] gfx_xlat(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] idx;
    logic [15:0]      ent;
    idx = v - GFX_LO;
    ent = 16'h0;
    if (v >= GFX_LO && v <= GFX_HI) begin
      ent = GFX_TABLE[idx[5:0]];
    end
    return (ent != 16'h0) ? {5'b0, ent} : v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ttcb_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module ttcb_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/terminal_text_cell_buffer.sv -----
// top level of the terminal text cell buffer: command sequencer around the cell ram
// depends on ttcb_pkg, ttcb_ram and terminal_text_cell_buffer_macros.svh
`default_nettype none
`include "terminal_text_cell_buffer_macros.svh"

// channel   | direction | contents
// s_axis    | in        | one command transaction
// m_axis    | out       | cursor and read cell, one per command
// cfg       | in        | register write, no read-back
//
// command steps: cursor commands, save/restore and write execute directly;
//   read waits for the registered ram read, put writes its cell after any scroll; tabs
//   run a remainder loop, then one step per stop;
//   scrolls and insert/delete read then write each moved cell and write each blanked cell,
//   all through the single read and single write port of the cell ram
// after reset every cell of the ram is swept to a blank, with s_axis_tready low
// the result register frees s_axis while a result waits on m_axis_tready

module terminal_text_cell_buffer
  import ttcb_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // action[3:0], row_arg[11:4], col_arg[20:12], count[28:21],
  // char_value[49:29], char_attrs[65:50]
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // cursor_row[5:0], cursor_col[13:6], cell_value[34:14], cell_attrs_out[50:35]
  output logic      [M_TDATA_W-1:0]  m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS + 1);
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int LEN_W  = $clog2(CELLS + 1);
  localparam int WIDE   = LEN_W + 10;

  // configuration registers
  logic [5:0]        scroll_top_q, scroll_bot_q;
  logic [ATTR_W-1:0] fill_attrs_q;
  logic              line_gfx_q;
  logic [7:0]        tab_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_top_q <= 6'd0;
      scroll_bot_q <= 6'd63;
      fill_attrs_q <= '0;
      line_gfx_q   <= 1'b0;
      tab_width_q  <= 8'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCROLL_TOP: scroll_top_q <= cfg_data_i[5:0];
        REG_SCROLL_BOT: scroll_bot_q <= cfg_data_i[5:0];
        REG_FILL_ATTRS: fill_attrs_q <= cfg_data_i;
        REG_LINE_GFX:   line_gfx_q   <= cfg_data_i[0];
        REG_TAB_WIDTH:  tab_width_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // cell ram
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  ttcb_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // sequencer state
  state_e               state_q, state_d;
  logic [ROW_W-1:0]     cur_row_q, cur_row_d, sav_row_q, sav_row_d;
  logic [COL_W-1:0]     cur_col_q, cur_col_d, sav_col_q, sav_col_d;
  action_e              act_q, act_d;
  logic signed [7:0]    rowa_q, rowa_d;
  logic signed [8:0]    cola_q, cola_d;
  logic [7:0]           cnt_q, cnt_d;
  logic [VAL_W-1:0]     cv_q, cv_d;
  logic [ATTR_W-1:0]    ca_q, ca_d;
  logic signed [8:0]    sc_org_q, sc_org_d, sc_n_q, sc_n_d;
  mv_mode_e             mv_mode_q, mv_mode_d;
  logic                 ret_put_q, ret_put_d;
  logic [ADDR_W-1:0]    mv_src_q, mv_src_d, mv_dst_q, mv_dst_d, bl_addr_q, bl_addr_d;
  logic [LEN_W-1:0]     mv_len_q, mv_len_d, bl_len_q, bl_len_d;
  logic                 mv_desc_q, mv_desc_d;
  logic [COL_W-1:0]     tab_rem_q, tab_rem_d;
  logic [7:0]           tab_n_q, tab_n_d;
  logic [VAL_W-1:0]     res_val_q, res_val_d;
  logic [ATTR_W-1:0]    res_att_q, res_att_d;
  logic [ADDR_W-1:0]    clr_addr_q, clr_addr_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_ROW_W-1:0] out_row_q, out_row_d;
  logic [OUT_COL_W-1:0] out_col_q, out_col_d;
  logic [VAL_W-1:0]     out_val_q, out_val_d;
  logic [ATTR_W-1:0]    out_att_q, out_att_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      sav_row_q   <= '0;
      sav_col_q   <= '0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      sav_row_q   <= sav_row_d;
      sav_col_q   <= sav_col_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and work registers
  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    rowa_q    <= rowa_d;
    cola_q    <= cola_d;
    cnt_q     <= cnt_d;
    cv_q      <= cv_d;
    ca_q      <= ca_d;
    sc_org_q  <= sc_org_d;
    sc_n_q    <= sc_n_d;
    mv_mode_q <= mv_mode_d;
    ret_put_q <= ret_put_d;
    mv_src_q  <= mv_src_d;
    mv_dst_q  <= mv_dst_d;
    mv_len_q  <= mv_len_d;
    mv_desc_q <= mv_desc_d;
    bl_addr_q <= bl_addr_d;
    bl_len_q  <= bl_len_d;
    tab_rem_q <= tab_rem_d;
    tab_n_q   <= tab_n_d;
    res_val_q <= res_val_d;
    res_att_q <= res_att_d;
    out_row_q <= out_row_d;
    out_col_q <= out_col_d;
    out_val_q <= out_val_d;
    out_att_q <= out_att_d;
  end

  // handshake side
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_att_q, out_val_q, out_col_q, out_row_q};

  // region bounds, bottom limited to the last screen row
  logic signed [8:0] top_s, bot_s;
  assign top_s = $signed({3'b0, scroll_top_q});
  assign bot_s = ({3'b0, scroll_bot_q} > 9'(ROWS - 1)) ? 9'(ROWS - 1) : {3'b0, scroll_bot_q};

  // absolute and relative cursor moves share one clamp
  logic signed [11:0] mr_s, mc_s;
  logic [ROW_W-1:0]   row_cl;
  logic [COL_W-1:0]   col_cl;

  always_comb begin
    mr_s = 12'(rowa_q);
    mc_s = 12'(cola_q);
    if (act_q == ACT_MOVEBY) begin
      mr_s = mr_s + $signed({5'b0, 7'(cur_row_q)});
      mc_s = mc_s + $signed({3'b0, 9'(cur_col_q)});
    end
    if (mr_s < 0) begin
      row_cl = '0;
    end else if (mr_s > $signed(12'(ROWS - 1))) begin
      row_cl = ROW_W'(ROWS - 1);
    end else begin
      row_cl = mr_s[ROW_W-1:0];
    end
    if (mc_s < 0) begin
      col_cl = '0;
    end else if (mc_s > $signed(12'(COLS))) begin
      col_cl = COL_W'(COLS);
    end else begin
      col_cl = mc_s[COL_W-1:0];
    end
  end

  logic cell_inside;
  assign cell_inside = !rowa_q[7] && !cola_q[8] && (9'(rowa_q) < 9'(ROWS))
                       && (10'(cola_q) < 10'(COLS));

  logic [ADDR_W-1:0] rw_addr;
  assign rw_addr = ADDR_W'(WIDE'(rowa_q[6:0]) * WIDE'(COLS) + WIDE'(cola_q[7:0]));

  logic wrap_pend, on_last_row;
  assign wrap_pend   = (cur_col_q == COL_W'(COLS));
  assign on_last_row = (cur_row_q == ROW_W'(ROWS - 1));

  // next state and datapath
  always_comb begin
    logic signed [8:0] org0, lo, lim, nn;
    logic [WIDE-1:0]   o, n, b, rows_mv, x, room, dx, shift, base;
    logic [WIDE-1:0]   w_src, w_dst, w_len, w_bl, w_blen;
    logic [9:0]        nx, stp;
    logic [ROW_W-1:0]  er;
    logic [COL_W-1:0]  ec;
    logic [VAL_W-1:0]  pv;

    state_d     = state_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    sav_row_d   = sav_row_q;
    sav_col_d   = sav_col_q;
    act_d       = act_q;
    rowa_d      = rowa_q;
    cola_d      = cola_q;
    cnt_d       = cnt_q;
    cv_d        = cv_q;
    ca_d        = ca_q;
    sc_org_d    = sc_org_q;
    sc_n_d      = sc_n_q;
    mv_mode_d   = mv_mode_q;
    ret_put_d   = ret_put_q;
    mv_src_d    = mv_src_q;
    mv_dst_d    = mv_dst_q;
    mv_len_d    = mv_len_q;
    mv_desc_d   = mv_desc_q;
    bl_addr_d   = bl_addr_q;
    bl_len_d    = bl_len_q;
    tab_rem_d   = tab_rem_q;
    tab_n_d     = tab_n_q;
    res_val_d   = res_val_q;
    res_att_d   = res_att_q;
    clr_addr_d  = clr_addr_q;
    out_valid_d = out_valid_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_val_d   = out_val_q;
    out_att_d   = out_att_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;

    org0 = '0; lo = '0; lim = '0; nn = '0;
    o = '0; n = '0; b = '0; rows_mv = '0; x = '0; room = '0; dx = '0; shift = '0;
    base = '0; w_src = '0; w_dst = '0; w_len = '0; w_bl = '0; w_blen = '0;
    nx = '0; stp = '0; er = '0; ec = '0; pv = '0;

    // result register drains independently of the sequencer
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // sweep the cell ram to blanks with reset attributes
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = {{ATTR_W{1'b0}}, SPACE_CHAR};
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (s_axis_tvalid) begin
          act_d     = action_e'(s_axis_tdata[3:0]);
          rowa_d    = s_axis_tdata[11:4];
          cola_d    = s_axis_tdata[20:12];
          cnt_d     = s_axis_tdata[28:21];
          cv_d      = s_axis_tdata[49:29];
          ca_d      = s_axis_tdata[65:50];
          res_val_d = '0;
          res_att_d = '0;
          state_d   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d   = ST_DONE;
        ret_put_d = 1'b0;
        case (act_q)
          ACT_PUT: begin
            if (wrap_pend && on_last_row) begin
              sc_org_d  = top_s;
              sc_n_d    = 9'sd1;
              mv_mode_d = MV_SCUP;
              ret_put_d = 1'b1;
              state_d   = ST_SC_SETUP;
            end else begin
              state_d = ST_PUT_WR;
            end
          end
          ACT_MOVETO, ACT_MOVEBY: begin
            cur_row_d = row_cl;
            cur_col_d = col_cl;
          end
          ACT_LINEFEED: begin
            if (9'(cur_row_q) == bot_s) begin
              sc_org_d  = top_s;
              sc_n_d    = 9'sd1;
              mv_mode_d = MV_SCUP;
              state_d   = ST_SC_SETUP;
            end else if (!on_last_row) begin
              cur_row_d = cur_row_q + 1'b1;
            end
          end
          ACT_TABFWD, ACT_TABBACK: begin
            if (cnt_q != 8'd0 && !wrap_pend) begin
              if (tab_width_q == 8'd0) begin
                // no stops: run to the edge
                cur_col_d = (act_q == ACT_TABFWD) ? COL_W'(COLS) : '0;
              end else begin
                tab_rem_d = cur_col_q;
                tab_n_d   = cnt_q;
                state_d   = ST_TAB_MOD;
              end
            end
          end
          ACT_INSCHARS, ACT_DELCHARS: begin
            if (!wrap_pend) begin
              mv_mode_d = (act_q == ACT_INSCHARS) ? MV_INS : MV_DEL;
              state_d   = ST_MV_SETUP;
            end
          end
          ACT_SCROLLUP, ACT_SCROLLDN: begin
            sc_org_d  = 9'(rowa_q);
            sc_n_d    = $signed({1'b0, cnt_q});
            mv_mode_d = (act_q == ACT_SCROLLUP) ? MV_SCUP : MV_SCDN;
            state_d   = ST_SC_SETUP;
          end
          ACT_SAVE: begin
            sav_row_d = cur_row_q;
            sav_col_d = cur_col_q;
          end
          ACT_RESTORE: begin
            cur_row_d = sav_row_q;
            cur_col_d = sav_col_q;
          end
          ACT_READ: begin
            ram_raddr = rw_addr;
            if (cell_inside) begin
              state_d = ST_RD_WAIT;
            end
          end
          ACT_WRITE: begin
            if (cell_inside) begin
              ram_we    = 1'b1;
              ram_waddr = rw_addr;
              ram_wdata = {ca_q, cv_q};
            end
          end
          default: ;
        endcase
      end

      // column modulo tab width by repeated subtraction
      ST_TAB_MOD: begin
        if (10'(tab_rem_q) >= 10'(tab_width_q)) begin
          tab_rem_d = COL_W'(10'(tab_rem_q) - 10'(tab_width_q));
        end else begin
          state_d = ST_TAB_STEP;
        end
      end

      // one tab stop per cycle
      ST_TAB_STEP: begin
        tab_rem_d = '0;
        tab_n_d   = tab_n_q - 1'b1;
        if (act_q == ACT_TABFWD) begin
          nx = 10'(cur_col_q) + 10'(tab_width_q) - 10'(tab_rem_q);
          if (nx >= 10'(COLS)) begin
            cur_col_d = COL_W'(COLS);
            state_d   = ST_DONE;
          end else begin
            cur_col_d = COL_W'(nx);
            if (tab_n_q == 8'd1) begin
              state_d = ST_DONE;
            end
          end
        end else begin
          stp = (tab_rem_q == '0) ? 10'(tab_width_q) : 10'(tab_rem_q);
          if (10'(cur_col_q) <= stp) begin
            cur_col_d = '0;
            state_d   = ST_DONE;
          end else begin
            cur_col_d = COL_W'(10'(cur_col_q) - stp);
            if (tab_n_q == 8'd1) begin
              state_d = ST_DONE;
            end
          end
        end
      end

      // check and limit the scroll, empty cases fall through
      ST_SC_SETUP: begin
        if ((top_s <= bot_s) && (sc_n_q != 9'sd0) && (sc_org_q < bot_s)) begin
          org0     = sc_org_q[8] ? 9'sd0 : sc_org_q;
          lo       = (org0 > top_s) ? org0 : top_s;
          lim      = bot_s - lo + 9'sd1;
          nn       = (sc_n_q > lim) ? lim : sc_n_q;
          sc_org_d = org0;
          sc_n_d   = nn;
          state_d  = ST_MV_SETUP;
        end else begin
          state_d = ret_put_q ? ST_PUT_WR : ST_DONE;
        end
      end

      // turn the command into one linear copy run and one blank run
      ST_MV_SETUP: begin
        o       = WIDE'(sc_org_q[7:0]);
        n       = WIDE'(sc_n_q[7:0]);
        b       = WIDE'(bot_s[7:0]);
        rows_mv = b - n - o + 1'b1;
        x       = WIDE'(cur_col_q);
        room    = WIDE'(COLS) - x;
        dx      = (WIDE'(cnt_q) < room) ? WIDE'(cnt_q) : room;
        shift   = room - dx;
        base    = WIDE'(cur_row_q) * WIDE'(COLS);
        case (mv_mode_q)
          MV_SCUP: begin
            w_dst     = o * WIDE'(COLS);
            w_src     = w_dst + n * WIDE'(COLS);
            w_len     = rows_mv * WIDE'(COLS);
            w_bl      = (b - n + 1'b1) * WIDE'(COLS);
            w_blen    = n * WIDE'(COLS);
            mv_desc_d = 1'b0;
          end
          MV_SCDN: begin
            w_dst     = b * WIDE'(COLS) + WIDE'(COLS - 1);
            w_src     = w_dst - n * WIDE'(COLS);
            w_len     = rows_mv * WIDE'(COLS);
            w_bl      = o * WIDE'(COLS);
            w_blen    = n * WIDE'(COLS);
            mv_desc_d = 1'b1;
          end
          MV_INS: begin
            w_dst     = base + WIDE'(COLS - 1);
            w_src     = w_dst - dx;
            w_len     = shift;
            w_bl      = base + x;
            w_blen    = dx;
            mv_desc_d = 1'b1;
          end
          default: begin
            w_dst     = base + x;
            w_src     = w_dst + dx;
            w_len     = shift;
            w_bl      = base + x + shift;
            w_blen    = dx;
            mv_desc_d = 1'b0;
          end
        endcase
        mv_dst_d  = ADDR_W'(w_dst);
        mv_src_d  = ADDR_W'(w_src);
        mv_len_d  = LEN_W'(w_len);
        bl_addr_d = ADDR_W'(w_bl);
        bl_len_d  = LEN_W'(w_blen);
        if (w_len != '0) begin
          state_d = ST_CP_RD;
        end else if (w_blen != '0) begin
          state_d = ST_BLANK;
        end else begin
          state_d = ret_put_q ? ST_PUT_WR : ST_DONE;
        end
      end

      // copy direction keeps each source read ahead of every overlapping write
      ST_CP_RD: begin
        ram_raddr = mv_src_q;
        state_d   = ST_CP_WR;
      end

      ST_CP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = mv_dst_q;
        ram_wdata = ram_rdata;
        mv_src_d  = mv_desc_q ? mv_src_q - 1'b1 : mv_src_q + 1'b1;
        mv_dst_d  = mv_desc_q ? mv_dst_q - 1'b1 : mv_dst_q + 1'b1;
        mv_len_d  = mv_len_q - 1'b1;
        if (mv_len_q == LEN_W'(1)) begin
          state_d = (bl_len_q != '0) ? ST_BLANK : (ret_put_q ? ST_PUT_WR : ST_DONE);
        end else begin
          state_d = ST_CP_RD;
        end
      end

      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = bl_addr_q;
        ram_wdata = {fill_attrs_q, SPACE_CHAR};
        bl_addr_d = bl_addr_q + 1'b1;
        bl_len_d  = bl_len_q - 1'b1;
        if (bl_len_q == LEN_W'(1)) begin
          state_d = ret_put_q ? ST_PUT_WR : ST_DONE;
        end
      end

      // pending wrap moves to column 0 of the next row (the last row stays put) first, then the character is stored
      ST_PUT_WR: begin
        er = cur_row_q;
        ec = cur_col_q;
        if (wrap_pend) begin
          er = on_last_row ? cur_row_q : cur_row_q + 1'b1;
          ec = '0;
        end
        pv        = line_gfx_q ? gfx_xlat(cv_q) : cv_q;
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(WIDE'(er) * WIDE'(COLS) + WIDE'(ec));
        ram_wdata = {ca_q, pv};
        cur_row_d = er;
        cur_col_d = ec + 1'b1;
        state_d   = ST_DONE;
      end

      ST_RD_WAIT: begin
        res_val_d = ram_rdata[VAL_W-1:0];
        res_att_d = ram_rdata[CELL_W-1:VAL_W];
        state_d   = ST_DONE;
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_row_d   = OUT_ROW_W'(cur_row_q);
          out_col_d   = OUT_COL_W'(cur_col_q);
          out_val_d   = res_val_q;
          out_att_d   = res_att_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  `TTCB_ASSERT(a_row_range, cur_row_q <= ROW_W'(ROWS - 1), "cursor row past last row")
  `TTCB_ASSERT(a_col_range, cur_col_q <= COL_W'(COLS), "cursor column past wrap column")
  `TTCB_ASSERT(a_waddr_range, !ram_we || (ram_waddr <= ADDR_W'(CELLS - 1)), "bad cell write")
  `TTCB_ASSERT_NEXT(a_accept_exec, s_axis_tvalid && s_axis_tready, state_q == ST_EXEC, "no decode")

endmodule

`default_nettype wire
